// ===== src/lfd_pkg.sv =====
// Shared types, constants and the reciprocal table of the Lagrange tap generator.
package lfd_pkg;

  localparam int MAX_TAPS  = 16;
  localparam int FRAC_BITS = 23;

  localparam int MAG_W  = 47;
  localparam int FAC_W  = 29;
  localparam int RCP_W  = 31;

  localparam logic [MAG_W-1:0] ONE_Q24 = MAG_W'(64'h0000_0000_0100_0000);
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_FAC,
    ST_LO,
    ST_HI,
    ST_ACC
  } state_t;

  typedef enum logic [1:0] {
    MUL_FAC,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic [3:0]         tap_index;
    logic               last;
  } tap_result_t;

  // round(2^30 / j), Q1.30; entry zero is never used.
  function automatic logic [RCP_W-1:0] recip(input logic [3:0] j);
    logic [RCP_W-1:0] r;
    case (j)
      4'd1:    r = 31'd1073741824;
      4'd2:    r = 31'd536870912;
      4'd3:    r = 31'd357913941;
      4'd4:    r = 31'd268435456;
      4'd5:    r = 31'd214748365;
      4'd6:    r = 31'd178956971;
      4'd7:    r = 31'd153391689;
      4'd8:    r = 31'd134217728;
      4'd9:    r = 31'd119304647;
      4'd10:   r = 31'd107374182;
      4'd11:   r = 31'd97612893;
      4'd12:   r = 31'd89478485;
      4'd13:   r = 31'd82595525;
      4'd14:   r = 31'd76695845;
      4'd15:   r = 31'd71582788;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/lagrange_fractional_delay_taps.sv =====
// Top level of the Lagrange fractional-delay tap generator: sequencer and datapath.
//
// One input transaction carries a fractional delay frac_delay (signed Q1.23).
// The block answers with tap_count coefficient transactions (signed Q8.24),
// in tap order, tap_index counting from zero and last set on the final one.
// A tap count of zero gives no output; counts above 16 are treated as 16.
// tap_count is written through the cfg channel (cfg_valid/cfg_ready), which
// is ready only while the block is idle; it resets to 4.
// Every product factor runs through the states STEP, FAC, LO, HI and ACC on the
// single shared 32 x 32 multiplier: one multiply forms |D-k|/|n-k| from the reciprocal
// table, two more multiply the running product by it in a low and a high part.
// A tap of an N-tap request is the product of its N-1 factors, and the taps are
// formed one after the other; in_stall is high while a request is in work and
// low again in the cycle after the last tap leaves the sequencer. The first
// coefficient appears once all factors of tap zero are formed.
// Results go through an output register: while out_stall holds the receiver
// off, the sequencer waits with the next finished tap, and the final one may
// still sit in the register while a new delay is accepted.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
module lagrange_fractional_delay_taps (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] frac_delay,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] coefficient,
  output logic [3:0]         tap_index,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  lfd_pkg::state_t state, state_next;

  logic [4:0] tap_count;
  logic [4:0] cnt;
  logic [4:0] cnt_clamp;
  logic [4:0] n;
  logic [4:0] k;

  logic signed [31:0]         dq;
  logic [lfd_pkg::MAG_W-1:0]  pmag;
  logic [lfd_pkg::MAG_W-1:0]  pmag_next;
  logic                       pneg;
  logic [lfd_pkg::FAC_W-1:0]  fac;
  logic [lfd_pkg::FAC_W-1:0]  lo_part;

  logic                     start;
  logic                     skip;
  logic                     issue_fac;
  logic                     ld_fac;
  logic                     ld_lo;
  logic                     ld_pmag;
  logic                     emit;
  logic                     out_free;
  lfd_pkg::mul_sel_t        mul_sel;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // Input conversion to the total delay D in signed Q.24.
  logic                          in_neg;
  logic [23:0]                   in_mag;
  logic [lfd_pkg::FRAC_BITS-1:0] fmag;
  logic [31:0]                   f24;
  logic [31:0]                   center_half;
  logic signed [31:0]            center;
  logic signed [31:0]            dq_new;

  // Per-factor terms.
  logic signed [31:0] diff;
  logic [31:0]        dmag;
  logic [3:0]         tap_dist;
  logic               k_above;
  logic [63:0]        fac_sum;
  logic [63:0]        lo_sum;
  logic [52:0]        acc_sum;

  lfd_pkg::tap_result_t result;
  lfd_pkg::tap_result_t result_q;

  assign cnt_clamp = (tap_count > 5'(lfd_pkg::MAX_TAPS)) ? 5'(lfd_pkg::MAX_TAPS) : tap_count;

  assign in_neg      = frac_delay[23];
  assign in_mag      = in_neg ? 24'(-frac_delay) : 24'(frac_delay);
  assign fmag        = in_mag[lfd_pkg::FRAC_BITS-1:0];
  assign f24         = 32'(fmag) << (24 - lfd_pkg::FRAC_BITS);
  // Even tap counts center on (N-1)/2, odd ones on N/2; both in half samples.
  assign center_half = cnt_clamp[0] ? {27'd0, cnt_clamp} : {27'd0, cnt_clamp} - 32'd1;
  assign center      = $signed((center_half << 23) - (in_neg ? 32'h0100_0000 : 32'd0));
  assign dq_new      = in_neg ? center - $signed(f24) : center + $signed(f24);

  assign diff     = dq - $signed({3'd0, k, 24'd0});
  assign dmag     = diff[31] ? 32'(-diff) : 32'(diff);
  assign k_above  = n < k;
  assign tap_dist = k_above ? 4'(k - n) : 4'(n - k);

  assign fac_sum = mul_p + (64'd1 << 29);
  assign lo_sum  = mul_p + (64'd1 << 23);
  assign acc_sum = mul_p[52:0] + {24'd0, lo_part};
  assign pmag_next = (acc_sum > {6'd0, lfd_pkg::MAG_MAX}) ? lfd_pkg::MAG_MAX
                                                          : acc_sum[lfd_pkg::MAG_W-1:0];

  always_comb begin
    case (mul_sel)
      lfd_pkg::MUL_FAC: begin
        mul_a = dmag;
        mul_b = {1'b0, lfd_pkg::recip(tap_dist)};
      end
      lfd_pkg::MUL_LO: begin
        mul_a = {8'd0, pmag[23:0]};
        mul_b = {3'd0, fac};
      end
      lfd_pkg::MUL_HI: begin
        mul_a = {9'd0, pmag[lfd_pkg::MAG_W-1:24]};
        mul_b = {3'd0, fac};
      end
      default: begin
        mul_a = dmag;
        mul_b = {1'b0, lfd_pkg::recip(tap_dist)};
      end
    endcase
  end

  lfd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Signed coefficient from sign and magnitude, saturated to 32 bits.
  always_comb begin
    if (!pneg) begin
      result.coefficient = (pmag > 47'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                        : $signed(pmag[31:0]);
    end else begin
      result.coefficient = (pmag > 47'h0000_8000_0000) ? 32'sh8000_0000
                                                        : $signed(~pmag[31:0] + 32'd1);
    end
    result.tap_index = n[3:0];
    result.last      = (n == cnt - 5'd1);
  end

  lfd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (emit),
    .din   (result),
    .stall (out_stall),
    .valid (out_valid),
    .free  (out_free),
    .dout  (result_q)
  );

  assign coefficient = result_q.coefficient;
  assign tap_index   = result_q.tap_index;
  assign last        = result_q.last;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      lfd_pkg::ST_IDLE: begin
        if (in_valid && (cnt_clamp != 5'd0)) begin
          state_next = lfd_pkg::ST_STEP;
        end
      end
      lfd_pkg::ST_STEP: begin
        if (k == cnt) begin
          if (out_free && (n == cnt - 5'd1)) begin
            state_next = lfd_pkg::ST_IDLE;
          end
        end else if (k != n) begin
          state_next = lfd_pkg::ST_FAC;
        end
      end
      lfd_pkg::ST_FAC: state_next = lfd_pkg::ST_LO;
      lfd_pkg::ST_LO:  state_next = lfd_pkg::ST_HI;
      lfd_pkg::ST_HI:  state_next = lfd_pkg::ST_ACC;
      lfd_pkg::ST_ACC: state_next = lfd_pkg::ST_STEP;
      default:         state_next = lfd_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    start     = 1'b0;
    skip      = 1'b0;
    issue_fac = 1'b0;
    ld_fac    = 1'b0;
    ld_lo     = 1'b0;
    ld_pmag   = 1'b0;
    emit      = 1'b0;
    mul_sel   = lfd_pkg::MUL_FAC;
    case (state)
      lfd_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        start     = in_valid && (cnt_clamp != 5'd0);
      end
      lfd_pkg::ST_STEP: begin
        if (k == cnt) begin
          emit = out_free;
        end else if (k == n) begin
          skip = 1'b1;
        end else begin
          issue_fac = 1'b1;
        end
      end
      lfd_pkg::ST_FAC: begin
        ld_fac = 1'b1;
      end
      lfd_pkg::ST_LO: begin
        mul_sel = lfd_pkg::MUL_LO;
      end
      lfd_pkg::ST_HI: begin
        ld_lo   = 1'b1;
        mul_sel = lfd_pkg::MUL_HI;
      end
      lfd_pkg::ST_ACC: begin
        ld_pmag = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfd_pkg::ST_IDLE;
      tap_count <= 5'd4;
      cnt       <= 5'd0;
      n         <= 5'd0;
      k         <= 5'd0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        tap_count <= cfg_data;
      end
      if (start) begin
        cnt <= cnt_clamp;
        n   <= 5'd0;
        k   <= 5'd0;
      end
      if (skip || ld_pmag) begin
        k <= k + 5'd1;
      end
      if (emit) begin
        n <= n + 5'd1;
        k <= 5'd0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dq <= dq_new;
    end
    if (start || emit) begin
      pmag <= lfd_pkg::ONE_Q24;
      pneg <= 1'b0;
    end
    if (issue_fac) begin
      pneg <= pneg ^ diff[31] ^ k_above;
    end
    if (ld_fac) begin
      fac <= fac_sum[58:30];
    end
    if (ld_lo) begin
      lo_part <= lo_sum[52:24];
    end
    if (ld_pmag) begin
      pmag <= pmag_next;
    end
  end

endmodule

// ===== src/lfd_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
module lfd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'd0, a} * {32'd0, b};
  end

endmodule

// ===== src/lfd_out_reg.sv =====
// Output register that holds one coefficient transaction until the receiver takes it.
module lfd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lfd_pkg::tap_result_t din,
  input  logic                 stall,
  output logic                 valid,
  output logic                 free,
  output lfd_pkg::tap_result_t dout
);

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule
